[rtl/bgd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and reset constants for the button gesture detector.
package bgd_pkg;

    // Default tick arithmetic width
    localparam int TICK_WIDTH_DEF = 32;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_WINDOW = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD         = 2'd2;

    // Configuration reset values
    localparam logic [15:0] DEBOUNCE_RESET     = 16'd35;
    localparam logic [15:0] CLICK_WINDOW_RESET = 16'd400;
    localparam logic [15:0] HOLD_RESET         = 16'd800;

    // Click counter saturation point
    localparam logic [7:0] CLICK_MAX = 8'd255;
    localparam logic [7:0] MULTI_CLICK = 8'd2;

    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_TOGGLE = 2'd1,
        GEST_NEXT   = 2'd2,
        GEST_PREV   = 2'd3
    } gesture_e;

    typedef enum logic {
        OP_EDGE  = 1'b0,
        OP_CHECK = 1'b1
    } op_kind_e;

    // Input request as seen on the port
    typedef struct packed {
        logic        action;
        logic [31:0] now_tick;
        logic        level_pressed;
    } req_t;

    // Result as seen on the port
    typedef struct packed {
        gesture_e    gesture;
        logic        deadline_valid;
        logic [31:0] wait_ticks;
    } res_t;

    // Classified request held in the queue
    typedef struct packed {
        op_kind_e    kind;
        logic        level;
        logic [31:0] now;
    } op_t;

    // Configuration registers
    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] click_window_ticks;
        logic [15:0] hold_ticks;
    } cfg_t;

    // Per-request status handed from the state update to the deadline stage
    typedef struct packed {
        gesture_e gesture;
        logic     deb_pending;
        logic     hold_pending;
        logic     click_pending;
    } snap_flags_t;

endpackage

[rtl/bgd_front.sv]
`timescale 1ns / 1ps
// Front end: takes requests, decodes the request kind and queues them.
module bgd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bgd_pkg::req_t req,
    output logic          op_valid,
    input  logic          op_ready,
    output bgd_pkg::op_t  op
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bgd_pkg::op_t queue_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;
    bgd_pkg::op_t     op_in;

    always_comb
    begin
        op_in.kind  = req.action ? bgd_pkg::OP_CHECK : bgd_pkg::OP_EDGE;
        op_in.level = req.level_pressed;
        op_in.now   = req.now_tick;
    end

    assign req_ready = (count_reg != CNT_W'(DEPTH));
    assign op_valid  = (count_reg != '0);
    assign op        = queue_mem[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = op_valid && op_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= op_in;
        end
    end

endmodule

[rtl/bgd_core.sv]
`timescale 1ns / 1ps
// Back end state update: debounce, hold and click detection, one request per cycle unless stalled by snap_ready.
module bgd_core #(
    parameter int TICK_WIDTH = bgd_pkg::TICK_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bgd_pkg::cfg_t           cfg,
    input  logic                    op_valid,
    output logic                    op_ready,
    input  bgd_pkg::op_t            op,
    output logic                    snap_valid,
    input  logic                    snap_ready,
    output bgd_pkg::snap_flags_t    snap_flags,
    output logic [TICK_WIDTH-1:0]   snap_now,
    output logic [TICK_WIDTH-1:0]   snap_raw_change,
    output logic [TICK_WIDTH-1:0]   snap_press,
    output logic [TICK_WIDTH-1:0]   snap_release
);

    logic                  raw_reg, raw_next;
    logic                  stable_reg, stable_next;
    logic                  hold_done_reg, hold_done_next;
    logic [7:0]            click_reg, click_next;
    logic [TICK_WIDTH-1:0] raw_change_reg, raw_change_next;
    logic [TICK_WIDTH-1:0] press_reg, press_next;
    logic [TICK_WIDTH-1:0] release_reg, release_next;

    logic                  snap_valid_reg;
    bgd_pkg::snap_flags_t  flags_reg, flags_next;
    logic [TICK_WIDTH-1:0] now_reg;
    logic [TICK_WIDTH-1:0] raw_change_snap_reg;
    logic [TICK_WIDTH-1:0] press_snap_reg;
    logic [TICK_WIDTH-1:0] release_snap_reg;

    logic [TICK_WIDTH-1:0] now;
    logic [TICK_WIDTH-1:0] deb_ext, hold_ext, cw_ext;
    logic [TICK_WIDTH-1:0] deb_dl, deb_hold_at, deb_click_due;
    logic [TICK_WIDTH-1:0] hold_at, click_due;
    logic [TICK_WIDTH-1:0] deb_diff, hold_diff, click_diff;
    logic                  take;
    logic                  is_check;
    logic                  process;
    logic                  deb_fire, deb_press, deb_release;
    logic                  stable_mid, hold_mid;
    logic [7:0]            click_mid;
    logic                  hold_fire, click_fire;
    bgd_pkg::gesture_e     gesture;

    assign take     = op_valid && op_ready;
    assign op_ready = !snap_valid_reg || snap_ready;
    assign is_check = (op.kind == bgd_pkg::OP_CHECK);
    assign now      = TICK_WIDTH'(op.now);
    assign process  = is_check || (op.level != raw_reg);

    assign deb_ext  = TICK_WIDTH'(cfg.debounce_ticks);
    assign hold_ext = TICK_WIDTH'(cfg.hold_ticks);
    assign cw_ext   = TICK_WIDTH'(cfg.click_window_ticks);

    // Debounce deadline; stable change is dated at the deadline itself
    assign deb_dl        = raw_change_reg + deb_ext;
    assign deb_hold_at   = raw_change_reg + deb_ext + hold_ext;
    assign deb_click_due = raw_change_reg + deb_ext + cw_ext;
    assign deb_diff      = now - deb_dl;

    assign deb_fire    = process && (raw_reg != stable_reg) && !deb_diff[TICK_WIDTH-1];
    assign deb_press   = deb_fire && raw_reg;
    assign deb_release = deb_fire && !raw_reg && !hold_done_reg;

    assign stable_mid = deb_fire ? raw_reg : stable_reg;
    assign hold_mid   = deb_press ? 1'b0 : hold_done_reg;
    assign click_mid  = (deb_release && (click_reg != bgd_pkg::CLICK_MAX))
                        ? click_reg + 8'd1 : click_reg;

    // Hold and click deadlines use the press/release time after debounce
    assign hold_at    = deb_press ? deb_hold_at : press_reg + hold_ext;
    assign click_due  = deb_release ? deb_click_due : release_reg + cw_ext;
    assign hold_diff  = now - hold_at;
    assign click_diff = now - click_due;

    assign hold_fire  = process && stable_mid && !hold_mid && !hold_diff[TICK_WIDTH-1];
    assign click_fire = process && !stable_mid && (click_mid != 8'd0)
                        && !click_diff[TICK_WIDTH-1];

    always_comb
    begin
        if (hold_fire)
        begin
            gesture = bgd_pkg::GEST_PREV;
        end
        else if (click_fire)
        begin
            gesture = (click_mid >= bgd_pkg::MULTI_CLICK) ? bgd_pkg::GEST_NEXT
                                                          : bgd_pkg::GEST_TOGGLE;
        end
        else
        begin
            gesture = bgd_pkg::GEST_NONE;
        end
    end

    always_comb
    begin
        stable_next     = stable_mid;
        hold_done_next  = hold_mid || hold_fire;
        click_next      = (hold_fire || click_fire) ? 8'd0 : click_mid;
        press_next      = deb_press ? deb_dl : press_reg;
        release_next    = deb_release ? deb_dl : release_reg;
        raw_next        = raw_reg;
        raw_change_next = raw_change_reg;
        if (!is_check && (op.level != raw_reg))
        begin
            raw_next        = op.level;
            raw_change_next = now;
        end
    end

    always_comb
    begin
        flags_next.gesture       = gesture;
        flags_next.deb_pending   = (raw_next != stable_next);
        flags_next.hold_pending  = stable_next && !hold_done_next;
        flags_next.click_pending = !stable_next && (click_next != 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg        <= 1'b0;
            stable_reg     <= 1'b0;
            hold_done_reg  <= 1'b0;
            click_reg      <= '0;
            raw_change_reg <= '0;
            press_reg      <= '0;
            release_reg    <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                raw_reg        <= raw_next;
                stable_reg     <= stable_next;
                hold_done_reg  <= hold_done_next;
                click_reg      <= click_next;
                raw_change_reg <= raw_change_next;
                press_reg      <= press_next;
                release_reg    <= release_next;
            end
            if (op_ready)
            begin
                snap_valid_reg <= op_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            flags_reg           <= flags_next;
            now_reg             <= now;
            raw_change_snap_reg <= raw_change_next;
            press_snap_reg      <= press_next;
            release_snap_reg    <= release_next;
        end
    end

    assign snap_valid      = snap_valid_reg;
    assign snap_flags      = flags_reg;
    assign snap_now        = now_reg;
    assign snap_raw_change = raw_change_snap_reg;
    assign snap_press      = press_snap_reg;
    assign snap_release    = release_snap_reg;

endmodule

[rtl/bgd_wait.sv]
`timescale 1ns / 1ps
// Back end deadline stages: earliest pending deadline and wait, plus result register.
module bgd_wait #(
    parameter int TICK_WIDTH = bgd_pkg::TICK_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bgd_pkg::cfg_t           cfg,
    input  logic                    snap_valid,
    output logic                    snap_ready,
    input  bgd_pkg::snap_flags_t    snap_flags,
    input  logic [TICK_WIDTH-1:0]   snap_now,
    input  logic [TICK_WIDTH-1:0]   snap_raw_change,
    input  logic [TICK_WIDTH-1:0]   snap_press,
    input  logic [TICK_WIDTH-1:0]   snap_release,
    output logic                    res_valid,
    input  logic                    res_ready,
    output bgd_pkg::res_t           res
);

    // Stage A: candidate deadlines
    logic                  a_valid_reg;
    bgd_pkg::snap_flags_t  a_flags_reg;
    logic [TICK_WIDTH-1:0] a_now_reg;
    logic [TICK_WIDTH-1:0] a_deb_reg, a_hold_reg, a_click_reg;
    logic                  a_ready;

    // Stage B: result register
    logic                  b_valid_reg;
    bgd_pkg::res_t         b_res_reg, b_res_next;
    logic                  b_ready;

    logic                  have0, have1, have2;
    logic                  take1, take2;
    logic [TICK_WIDTH-1:0] dl1, dl2;
    logic [TICK_WIDTH-1:0] d1, d2, reach_diff;
    logic [TICK_WIDTH-1:0] wait_full;
    logic [31:0]           wait_out;

    assign b_ready    = !b_valid_reg || res_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign snap_ready = a_ready;

    // Earliest of up to three deadlines, wrap-aware
    assign have0 = a_flags_reg.deb_pending;
    assign d1    = a_hold_reg - a_deb_reg;
    assign take1 = a_flags_reg.hold_pending && (!have0 || d1[TICK_WIDTH-1]);
    assign have1 = have0 || a_flags_reg.hold_pending;
    assign dl1   = take1 ? a_hold_reg : a_deb_reg;
    assign d2    = a_click_reg - dl1;
    assign take2 = a_flags_reg.click_pending && (!have1 || d2[TICK_WIDTH-1]);
    assign have2 = have1 || a_flags_reg.click_pending;
    assign dl2   = take2 ? a_click_reg : dl1;

    assign reach_diff = a_now_reg - dl2;
    assign wait_full  = (have2 && reach_diff[TICK_WIDTH-1]) ? dl2 - a_now_reg : '0;

    generate
        if (TICK_WIDTH > 32)
        begin : g_wait_sat
            assign wait_out = (wait_full[TICK_WIDTH-1:32] != '0) ? '1 : wait_full[31:0];
        end
        else
        begin : g_wait_ext
            assign wait_out = 32'(wait_full);
        end
    endgenerate

    always_comb
    begin
        b_res_next.gesture        = a_flags_reg.gesture;
        b_res_next.deadline_valid = have2;
        b_res_next.wait_ticks     = wait_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= snap_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid && a_ready)
        begin
            a_flags_reg <= snap_flags;
            a_now_reg   <= snap_now;
            a_deb_reg   <= snap_raw_change + TICK_WIDTH'(cfg.debounce_ticks);
            a_hold_reg  <= snap_press + TICK_WIDTH'(cfg.hold_ticks);
            a_click_reg <= snap_release + TICK_WIDTH'(cfg.click_window_ticks);
        end
        if (a_valid_reg && b_ready)
        begin
            b_res_reg <= b_res_next;
        end
    end

    assign res_valid = b_valid_reg;
    assign res       = b_res_reg;

endmodule

[rtl/button_gesture_detector.sv]
`timescale 1ns / 1ps
// Top level of the button gesture detector: configuration registers and block wiring.
//
// Debounces one button and classifies its gestures. Each request carries a 32-bit
// wrapping timestamp and is either a raw level edge (action 0) or a time check
// (action 1). A raw level that differs from the stable level becomes stable once
// debounce_ticks have passed since the raw change, dated at that deadline. A stable
// press held for hold_ticks reports 'previous'; after release, once click_window_ticks
// run out, one click reports 'toggle' and two or more report 'next' (count saturates
// at 255). Every request returns exactly one result, which also gives the ticks left
// until the earliest pending debounce, hold or click deadline (0 if already reached,
// deadline_valid low if none). All tick compares use the wrapping signed difference at
// TICK_WIDTH bits. Throughput is one request per clock unless res_ready stalls the
// pipeline: the whole state update is combinational in the core. A request passes from
// acceptance to res_valid through the queue, state update, deadline sums, and the
// earliest-deadline and wait into the result register. req_ready comes from the
// two-entry input queue and does not depend on res_ready in the same cycle. Configuration
// writes take effect at once and are to be issued only while no request is in flight.

module button_gesture_detector #(
    parameter int TICK_WIDTH = bgd_pkg::TICK_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel
    input  logic                              req_valid,
    output logic                              req_ready,
    input  bgd_pkg::req_t                     req,
    // Result channel
    output logic                              res_valid,
    input  logic                              res_ready,
    output bgd_pkg::res_t                     res,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [bgd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [15:0]                       cfg_data
);

    bgd_pkg::cfg_t cfg_reg, cfg_next;

    logic                  op_valid;
    logic                  op_ready;
    bgd_pkg::op_t          op;

    logic                  snap_valid;
    logic                  snap_ready;
    bgd_pkg::snap_flags_t  snap_flags;
    logic [TICK_WIDTH-1:0] snap_now;
    logic [TICK_WIDTH-1:0] snap_raw_change;
    logic [TICK_WIDTH-1:0] snap_press;
    logic [TICK_WIDTH-1:0] snap_release;

    // Register writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bgd_pkg::CFG_DEBOUNCE:     cfg_next.debounce_ticks     = cfg_data;
                bgd_pkg::CFG_CLICK_WINDOW: cfg_next.click_window_ticks = cfg_data;
                bgd_pkg::CFG_HOLD:         cfg_next.hold_ticks         = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks     <= bgd_pkg::DEBOUNCE_RESET;
            cfg_reg.click_window_ticks <= bgd_pkg::CLICK_WINDOW_RESET;
            cfg_reg.hold_ticks         <= bgd_pkg::HOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept, decode and queue requests
    bgd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op)
    );

    // Back: button state update and gesture decision
    bgd_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .op_valid        (op_valid),
        .op_ready        (op_ready),
        .op              (op),
        .snap_valid      (snap_valid),
        .snap_ready      (snap_ready),
        .snap_flags      (snap_flags),
        .snap_now        (snap_now),
        .snap_raw_change (snap_raw_change),
        .snap_press      (snap_press),
        .snap_release    (snap_release)
    );

    // Back: earliest deadline, wait and result register
    bgd_wait #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_wait (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .snap_valid      (snap_valid),
        .snap_ready      (snap_ready),
        .snap_flags      (snap_flags),
        .snap_now        (snap_now),
        .snap_raw_change (snap_raw_change),
        .snap_press      (snap_press),
        .snap_release    (snap_release),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

endmodule
